// ===== hdl/wvp_pkg.sv =====
// Shared constants, register indexes and helpers for weighted_vertex_proposal.
// No dependencies.
package wvp_pkg;

  // Default sizing of the interaction table
  localparam int FIELDS_MAX_DEF = 64;
  localparam int INDEX_BITS_DEF = 4;

  // Configuration register indexes
  localparam logic [1:0] REG_BETA          = 2'd0;
  localparam logic [1:0] REG_ALPHA_DIAG    = 2'd1;
  localparam logic [1:0] REG_ALPHA_OFFDIAG = 2'd2;
  localparam logic [1:0] REG_FIELD_COUNT   = 2'd3;

  // Request types
  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_PROPOSE = 1'b1;

  // Reset values of the registers
  localparam logic [31:0] BETA_RST        = 32'd65536;
  localparam logic [16:0] ALPHA_DIAG_RST  = 17'd32768;
  localparam logic [17:0] ALPHA_OFF_RST   = 18'd0;
  localparam logic [6:0]  FIELD_COUNT_RST = 7'd1;

  localparam int SUM_W    = 38;
  localparam int TARGET_W = 54;
  localparam int WEIGHT_W = 48;

  localparam logic [SUM_W-1:0]  SUM_MAX = {SUM_W{1'b1}};
  localparam logic [46:0]       W_MAX   = {47{1'b1}};
  localparam logic [17:0]       ONE_Q16 = 18'd65536;

  // Magnitude of a signed Q16.16 coupling; 32 bits hold 2^31
  function automatic logic [31:0] abs32(input logic [31:0] v);
    abs32 = v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

// ===== hdl/wvp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module wvp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/weighted_vertex_proposal.sv =====
// Top level of weighted_vertex_proposal: interaction table, roulette selection sequencer.
// Depends on wvp_pkg and wvp_ram.
//
// Usage: a load request (req_type 0) writes one interaction term into the table and
// adds its absolute coupling to a saturating 38-bit running sum and gives
// no result. A propose request (req_type 1) picks a term by roulette
// selection against r_select times the running sum and returns one result with the
// vertex time, the optionally swapped indices, the signed saturated weight and the
// alpha shifts. A propose first forms the products, then the target and the weight
// magnitude, then walks the table from entry 0 through the single table RAM port,
// whose read data is registered, up to entry n-1, where n is field_count clamped to
// 1..FIELDS_MAX, stopping early at the selected entry, and last forms the result. The
// next request is taken in the cycle after the result is loaded. Only
// one request is in work at a time; a finished result waits in the output register
// while the next request is taken. Config writes are accepted at any time but belong
// to idle periods. The table content is undefined until each entry has been loaded.
module weighted_vertex_proposal #(
  parameter int FIELDS_MAX = wvp_pkg::FIELDS_MAX_DEF,
  parameter int INDEX_BITS = wvp_pkg::INDEX_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // request channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                req_type,
  input  logic [5:0]          entry_index,
  input  logic [3:0]          zone_a,
  input  logic [3:0]          orb_a_out,
  input  logic [3:0]          orb_a_in,
  input  logic [3:0]          zone_b,
  input  logic [3:0]          orb_b_out,
  input  logic [3:0]          orb_b_in,
  input  logic signed [31:0]  coupling,
  input  logic [15:0]         r_time,
  input  logic [15:0]         r_select,
  input  logic [1:0]          coin_bits,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         vertex_time,
  output logic [3:0]          zone_1,
  output logic [3:0]          zone_2,
  output logic [3:0]          orb_1_out,
  output logic [3:0]          orb_1_in,
  output logic [3:0]          orb_2_out,
  output logic [3:0]          orb_2_in,
  output logic signed [47:0]  weight_u,
  output logic signed [17:0]  alpha_1,
  output logic signed [17:0]  alpha_2,
  output logic [5:0]          field_index,
  // configuration channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import wvp_pkg::*;

  localparam int AW      = (FIELDS_MAX > 1) ? $clog2(FIELDS_MAX) : 1;
  localparam int IB      = INDEX_BITS;
  localparam int ENTRY_W = 6 * IB + 32;
  localparam int CUM_W   = 32 + AW;
  localparam int CMP_W   = (CUM_W + 16 > TARGET_W) ? CUM_W + 16 : TARGET_W;

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  // Configuration registers
  logic [31:0] beta;
  logic [16:0] alpha_diag;
  logic [17:0] alpha_offdiag;
  logic [6:0]  field_count;

  logic [2:0]  state;
  logic [SUM_W-1:0] coupling_sum;

  // Captured propose request
  logic [15:0] r_time_q;
  logic [15:0] r_select_q;
  logic [1:0]  coin_q;

  // Products and derived terms
  logic [37:0] prod_t_hi;   // r_select * sum[37:16]
  logic [31:0] prod_t_lo;   // r_select * sum[15:0]
  logic [53:0] prod_m_hi;   // beta * sum[37:16]
  logic [47:0] prod_m_lo;   // beta * sum[15:0]
  logic [47:0] prod_vt;     // beta * r_time
  logic [TARGET_W-1:0] target;
  logic [46:0] mag;
  logic [31:0] vt_q;

  // Scan state
  logic [AW-1:0]    scan_idx;
  logic [AW-1:0]    didx;
  logic             dvalid;
  logic [CUM_W-1:0] cum;
  logic [AW-1:0]    last;

  // Selected entry
  logic [ENTRY_W-1:0] sel;
  logic [AW-1:0]      sel_idx;

  // RAM
  logic               ram_we;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  logic in_acc;
  logic ld_ok;
  logic out_load;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign ld_ok     = (32'(entry_index) < 32'(FIELDS_MAX));
  assign ram_we    = in_acc && (req_type == REQ_LOAD) && ld_ok;

  assign ram_wdata = {IB'(orb_b_in), IB'(orb_b_out), IB'(zone_b),
                      IB'(orb_a_in), IB'(orb_a_out), IB'(zone_a), coupling};

  wvp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (FIELDS_MAX)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(entry_index)),
    .wdata (ram_wdata),
    .raddr (scan_idx),
    .rdata (ram_rdata)
  );

  // Last entry index in use, field_count clamped to 1..FIELDS_MAX
  always_comb begin
    if (field_count == 7'd0) begin
      last = '0;
    end else if (32'(field_count) > 32'(FIELDS_MAX)) begin
      last = AW'(FIELDS_MAX - 1);
    end else begin
      last = AW'(field_count - 7'd1);
    end
  end

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      beta          <= BETA_RST;
      alpha_diag    <= ALPHA_DIAG_RST;
      alpha_offdiag <= ALPHA_OFF_RST;
      field_count   <= FIELD_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BETA:          beta          <= cfg_data;
        REG_ALPHA_DIAG:    alpha_diag    <= cfg_data[16:0];
        REG_ALPHA_OFFDIAG: alpha_offdiag <= cfg_data[17:0];
        REG_FIELD_COUNT:   field_count   <= cfg_data[6:0];
        default:           beta          <= beta;
      endcase
    end
  end

  // Running sum of absolute couplings, saturating
  logic [SUM_W:0] sum_next;
  assign sum_next = {1'b0, coupling_sum} + (SUM_W + 1)'(abs32(coupling));

  always_ff @(posedge clk) begin
    if (rst) begin
      coupling_sum <= '0;
    end else if (ram_we) begin
      coupling_sum <= sum_next[SUM_W] ? SUM_MAX : sum_next[SUM_W-1:0];
    end
  end

  // Scan compare: cumulative magnitude at the entry now out of the RAM
  logic [CUM_W-1:0] cum_next;
  logic             hit;
  assign cum_next = cum + CUM_W'(abs32(ram_rdata[31:0]));
  assign hit = (CMP_W'({cum_next, 16'h0}) >= CMP_W'(target)) || (didx == last);

  // Weight magnitude, saturated to 2^47-1
  logic [54:0] mag_full;
  assign mag_full = {1'b0, prod_m_hi} + 55'(prod_m_lo[47:16]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      dvalid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc && (req_type == REQ_PROPOSE)) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_SUM;
        end
        S_SUM: begin
          state  <= S_SCAN;
          dvalid <= 1'b0;
        end
        S_SCAN: begin
          if (dvalid && hit) begin
            state  <= S_FIN;
            dvalid <= 1'b0;
          end else begin
            dvalid <= 1'b1;
          end
        end
        S_FIN: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc && (req_type == REQ_PROPOSE)) begin
      r_time_q   <= r_time;
      r_select_q <= r_select;
      coin_q     <= coin_bits;
    end
    if (state == S_MUL) begin
      prod_t_hi <= 38'(r_select_q) * 38'(coupling_sum[37:16]);
      prod_t_lo <= 32'(r_select_q) * 32'(coupling_sum[15:0]);
      prod_m_hi <= 54'(beta) * 54'(coupling_sum[37:16]);
      prod_m_lo <= 48'(beta) * 48'(coupling_sum[15:0]);
      prod_vt   <= 48'(beta) * 48'(r_time_q);
    end
    if (state == S_SUM) begin
      target   <= {prod_t_hi, 16'h0} + TARGET_W'(prod_t_lo);
      mag      <= (mag_full > 55'(W_MAX)) ? W_MAX : mag_full[46:0];
      vt_q     <= prod_vt[47:16];
      scan_idx <= '0;
      cum      <= '0;
    end
    if (state == S_SCAN) begin
      // issue one read per cycle, hold at the last entry in use
      didx <= scan_idx;
      if (scan_idx != last) begin
        scan_idx <= scan_idx + AW'(1);
      end
      if (dvalid) begin
        cum <= cum_next;
        if (hit) begin
          sel     <= ram_rdata;
          sel_idx <= didx;
        end
      end
    end
  end

  // Result forming
  logic [IB-1:0] e_idx [6];
  logic          neg;
  logic          diag;
  logic [47:0]   wt;
  logic [17:0]   a1;
  logic [17:0]   a2;
  logic [17:0]   ad_neg;
  logic [17:0]   ad_comp;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      e_idx[k] = sel[32 + IB*k +: IB];
    end
    neg     = sel[31] && (mag != '0);
    wt      = neg ? (48'd0 - {1'b0, mag}) : {1'b0, mag};
    diag    = (e_idx[1] == e_idx[2]) && (e_idx[4] == e_idx[5]);
    ad_neg  = 18'd0 - {1'b0, alpha_diag};
    ad_comp = ONE_Q16 - {1'b0, alpha_diag};
    if (!diag) begin
      a1 = alpha_offdiag;
      a2 = alpha_offdiag;
    end else if (neg) begin
      a1 = ad_neg;
      a2 = ad_neg;
    end else if (coin_q[1]) begin
      a1 = ad_comp;
      a2 = {1'b0, alpha_diag};
    end else begin
      a1 = {1'b0, alpha_diag};
      a2 = ad_comp;
    end
  end

  assign out_load = (state == S_FIN) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      vertex_time <= vt_q;
      weight_u    <= wt;
      alpha_1     <= a1;
      alpha_2     <= a2;
      field_index <= 6'(sel_idx);
      // coin bit 0 swaps the a and b ends
      if (coin_q[0]) begin
        zone_1    <= 4'(e_idx[3]);
        zone_2    <= 4'(e_idx[0]);
        orb_1_out <= 4'(e_idx[4]);
        orb_1_in  <= 4'(e_idx[5]);
        orb_2_out <= 4'(e_idx[1]);
        orb_2_in  <= 4'(e_idx[2]);
      end else begin
        zone_1    <= 4'(e_idx[0]);
        zone_2    <= 4'(e_idx[3]);
        orb_1_out <= 4'(e_idx[1]);
        orb_1_in  <= 4'(e_idx[2]);
        orb_2_out <= 4'(e_idx[4]);
        orb_2_in  <= 4'(e_idx[5]);
      end
    end
  end

endmodule
